FILE: rtl/slfmh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package slfmh_pkg;

  typedef struct packed {
    logic       cmd;
    logic [3:0] month;
    logic [5:0] day_of_month;
    logic [7:0] days_since_may1;
  } in_item_t;

  typedef struct packed {
    logic [15:0] leaf_moisture;
    logic [15:0] wood_moisture;
    logic [13:0] leaf_heat;
    logic [13:0] wood_heat;
    logic [7:0]  season_day;
  } out_item_t;

  // Input command codes
  localparam logic CMD_DATE = 1'b0;
  localparam logic CMD_DAYS = 1'b1;

  // Divider lanes
  localparam int NLANE       = 2;
  localparam int LANE_LEAF_M = 0;
  localparam int LANE_WOOD_M = 1;

  localparam int DIV_W = 20;  // divisor and partial remainder width
  localparam int HW    = 36;  // heat polynomial accumulator width, scaled by 1e6

  // Date handling
  localparam logic [7:0] SEASON_MAX  = 8'd184;
  localparam logic [8:0] MAY1_OFFSET = 9'd121;
  localparam logic [8:0] OCT31_CAP   = 9'd304;
  localparam logic [3:0] MONTH_MAX   = 4'd12;
  localparam logic [5:0] DAY_MAX     = 6'd31;

  localparam logic [8:0] MONTH_START [12] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  // Moisture: 100000 * 2^F / (DEN0 + DEN1 * d); index 0 is leaf, 1 is wood
  localparam logic [16:0]      MOIST_NUM = 17'd100000;
  localparam logic [DIV_W-1:0] DEN0 [2] = '{20'd72600, 20'd145400};
  localparam logic [DIV_W-1:0] DEN1 [2] = '{20'd877, 20'd650};
  localparam logic [15:0]      MOIST_MAX = 16'hFFFF;

  // Heat: (H0 - H1 d + H2 d^2 - H3 d^3) / 1e6, rounded half up
  localparam logic [HW-1:0] H0 [2] = '{36'd9613000000, 36'd9509000000};
  localparam logic [HW-1:0] H1 [2] = '{36'd1000000, 36'd10740000};
  localparam logic [HW-1:0] H2 [2] = '{36'd136900, 36'd135900};
  localparam logic [HW-1:0] H3 [2] = '{36'd365, 36'd405};
  localparam logic [HW-1:0]    HEAT_HALF = 36'd500000;
  localparam logic [13:0]      HEAT_MAX  = 14'h3FFF;

  // Divide by 1e6: drop 2^6 with a shift, then multiply by ceil(2^42 / 15625),
  // which is exact for any shifted value below 2^28.
  localparam int HEAT_PRE   = 6;
  localparam int HEAT_YW    = 28;
  localparam int HEAT_RW    = 29;
  localparam int HEAT_SHIFT = 42;
  localparam logic [HEAT_RW-1:0] HEAT_RECIP = 29'd281474977;

endpackage
`default_nettype wire

FILE: rtl/slfmh_front.sv
`timescale 1ns / 1ps
`default_nettype none
module slfmh_front #(
  parameter int MOIST_FRAC_BITS = 14,
  parameter int DVW = (MOIST_FRAC_BITS + 18 > 34) ? MOIST_FRAC_BITS + 18 : 34
) (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  logic                                            up_valid,
  output logic                                            up_ready,
  input  slfmh_pkg::in_item_t                             up_item,
  output logic                                            dn_valid,
  input  logic                                            dn_ready,
  output logic [slfmh_pkg::NLANE-1:0][DVW-1:0]            dn_dvd,
  output logic [slfmh_pkg::NLANE-1:0][slfmh_pkg::DIV_W-1:0] dn_dsr,
  output logic [1:0][13:0]                                dn_heat,
  output logic [7:0]                                      dn_day
);

  localparam int W = slfmh_pkg::DIV_W;
  localparam int H = slfmh_pkg::HW;
  localparam int HPW = slfmh_pkg::HEAT_YW + slfmh_pkg::HEAT_RW;
  localparam int HQW = HPW - slfmh_pkg::HEAT_SHIFT;
  localparam logic [DVW-1:0] MNUM = DVW'(slfmh_pkg::MOIST_NUM) << MOIST_FRAC_BITS;

  logic rdy1, rdy2, rdy3, rdy4, rdy5;
  logic v1_r, v2_r, v3_r, v4_r, v5_r;

  assign rdy5     = !v5_r || dn_ready;
  assign rdy4     = !v4_r || rdy5;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign up_ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= up_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
    end
  end

  // Stage 1: date to season day
  logic [3:0] m_c;
  logic [5:0] dy_c;
  logic [8:0] t_c;
  logic [7:0] d_nxt;
  logic [7:0] d1_r;

  always_comb begin
    m_c = up_item.month;
    if (m_c == 4'd0) m_c = 4'd1;
    else if (m_c > slfmh_pkg::MONTH_MAX) m_c = slfmh_pkg::MONTH_MAX;
    dy_c = up_item.day_of_month;
    if (dy_c == 6'd0) dy_c = 6'd1;
    else if (dy_c > slfmh_pkg::DAY_MAX) dy_c = slfmh_pkg::DAY_MAX;
    t_c = slfmh_pkg::MONTH_START[m_c - 4'd1] + 9'(dy_c);
    if (t_c > slfmh_pkg::OCT31_CAP) t_c = slfmh_pkg::OCT31_CAP;
    if (up_item.cmd == slfmh_pkg::CMD_DAYS) begin
      d_nxt = (up_item.days_since_may1 > slfmh_pkg::SEASON_MAX) ?
              slfmh_pkg::SEASON_MAX : up_item.days_since_may1;
    end else begin
      d_nxt = (t_c > slfmh_pkg::MAY1_OFFSET) ? 8'(t_c - slfmh_pkg::MAY1_OFFSET) : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && up_valid) d1_r <= d_nxt;
  end

  // Stage 2: square, moisture denominators, constant and linear heat terms
  logic [7:0]             d2_r;
  logic [15:0]            s2_nxt, s2_r;
  logic [1:0][W-1:0]      den2_nxt, den2_r;
  logic [1:0][H-1:0]      acc2_nxt, acc2_r;

  always_comb begin
    s2_nxt = 16'(d1_r) * 16'(d1_r);
    for (int j = 0; j < 2; j++) begin
      den2_nxt[j] = slfmh_pkg::DEN0[j] + slfmh_pkg::DEN1[j] * W'(d1_r);
      acc2_nxt[j] = slfmh_pkg::H0[j] - slfmh_pkg::H1[j] * H'(d1_r);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      d2_r   <= d1_r;
      s2_r   <= s2_nxt;
      den2_r <= den2_nxt;
      acc2_r <= acc2_nxt;
    end
  end

  // Stage 3: cube, quadratic heat term, rounded moisture dividends
  logic [7:0]            d3_r;
  logic [23:0]           s3_nxt, s3_r;
  logic [1:0][W-1:0]     den3_r;
  logic [1:0][H-1:0]     acc3_nxt, acc3_r;
  logic [1:0][DVW-1:0]   mdvd_nxt, mdvd_r;

  always_comb begin
    s3_nxt = 24'(s2_r) * 24'(d2_r);
    for (int j = 0; j < 2; j++) begin
      acc3_nxt[j] = acc2_r[j] + slfmh_pkg::H2[j] * H'(s2_r);
      mdvd_nxt[j] = MNUM + DVW'(den2_r[j] >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) begin
      d3_r   <= d2_r;
      s3_r   <= s3_nxt;
      den3_r <= den2_r;
      acc3_r <= acc3_nxt;
      mdvd_r <= mdvd_nxt;
    end
  end

  // Stage 4: cubic heat term, half-up bias, floor at zero
  logic [1:0][H-1:0]                       heat_c;
  logic [1:0][H-1:0]                       hdvd_nxt, hdvd4_r;
  logic [slfmh_pkg::NLANE-1:0][DVW-1:0]    dvd_nxt, dvd4_r;
  logic [slfmh_pkg::NLANE-1:0][W-1:0]      dsr_nxt, dsr4_r;
  logic [7:0]                              d4_r;

  always_comb begin
    for (int j = 0; j < 2; j++) begin
      heat_c[j]   = acc3_r[j] - slfmh_pkg::H3[j] * H'(s3_r);
      hdvd_nxt[j] = heat_c[j][H-1] ? '0 : heat_c[j] + slfmh_pkg::HEAT_HALF;
    end
    dvd_nxt[slfmh_pkg::LANE_LEAF_M] = mdvd_r[0];
    dvd_nxt[slfmh_pkg::LANE_WOOD_M] = mdvd_r[1];
    dsr_nxt[slfmh_pkg::LANE_LEAF_M] = den3_r[0];
    dsr_nxt[slfmh_pkg::LANE_WOOD_M] = den3_r[1];
  end

  always_ff @(posedge clk) begin
    if (rdy4 && v3_r) begin
      d4_r    <= d3_r;
      hdvd4_r <= hdvd_nxt;
      dvd4_r  <= dvd_nxt;
      dsr4_r  <= dsr_nxt;
    end
  end

  // Stage 5: heat divide by 1e6 through the reciprocal multiply, clamp to 14 bits
  logic [1:0][slfmh_pkg::HEAT_YW-1:0]      hy_c;
  logic [1:0][HPW-1:0]                     hp_c;
  logic [1:0][HQW-1:0]                     hq_c;
  logic [1:0][13:0]                        heat_nxt, heat5_r;
  logic [slfmh_pkg::NLANE-1:0][DVW-1:0]    dvd5_r;
  logic [slfmh_pkg::NLANE-1:0][W-1:0]      dsr5_r;
  logic [7:0]                              d5_r;

  always_comb begin
    for (int j = 0; j < 2; j++) begin
      hy_c[j]     = hdvd4_r[j][slfmh_pkg::HEAT_PRE +: slfmh_pkg::HEAT_YW];
      hp_c[j]     = HPW'(hy_c[j]) * HPW'(slfmh_pkg::HEAT_RECIP);
      hq_c[j]     = hp_c[j][slfmh_pkg::HEAT_SHIFT +: HQW];
      heat_nxt[j] = (hq_c[j] > HQW'(slfmh_pkg::HEAT_MAX)) ?
                    slfmh_pkg::HEAT_MAX : hq_c[j][13:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5 && v4_r) begin
      d5_r    <= d4_r;
      heat5_r <= heat_nxt;
      dvd5_r  <= dvd4_r;
      dsr5_r  <= dsr4_r;
    end
  end

  assign dn_valid = v5_r;
  assign dn_dvd   = dvd5_r;
  assign dn_dsr   = dsr5_r;
  assign dn_heat  = heat5_r;
  assign dn_day   = d5_r;

endmodule
`default_nettype wire

FILE: rtl/slfmh_div.sv
`timescale 1ns / 1ps
`default_nettype none
module slfmh_div #(
  parameter int MOIST_FRAC_BITS = 14,
  parameter int DVW  = (MOIST_FRAC_BITS + 18 > 34) ? MOIST_FRAC_BITS + 18 : 34,
  parameter int NSTG = (MOIST_FRAC_BITS + 1 > 14) ? MOIST_FRAC_BITS + 1 : 14
) (
  input  logic                                              clk,
  input  logic                                              rst_n,
  input  logic                                              up_valid,
  output logic                                              up_ready,
  input  logic [slfmh_pkg::NLANE-1:0][DVW-1:0]              up_dvd,
  input  logic [slfmh_pkg::NLANE-1:0][slfmh_pkg::DIV_W-1:0] up_dsr,
  input  logic [1:0][13:0]                                  up_heat,
  input  logic [7:0]                                        up_day,
  output logic                                              dn_valid,
  input  logic                                              dn_ready,
  output logic [slfmh_pkg::NLANE-1:0][NSTG-1:0]             dn_q,
  output logic [1:0][13:0]                                  dn_heat,
  output logic [7:0]                                        dn_day
);

  localparam int W = slfmh_pkg::DIV_W;
  localparam int L = slfmh_pkg::NLANE;

  logic                        v_r    [NSTG];
  logic                        rdy    [NSTG];
  logic [L-1:0][W-1:0]         rem_r  [NSTG];
  logic [L-1:0][W-1:0]         dsr_r  [NSTG];
  logic [L-1:0][NSTG-1:0]      lo_r   [NSTG];
  logic [L-1:0][NSTG-1:0]      q_r    [NSTG];
  logic [1:0][13:0]            heat_r [NSTG];
  logic [7:0]                  day_r  [NSTG];

  // The quotient fits in NSTG bits, so the bits above them start out below the divisor.
  logic [L-1:0][W-1:0]    rem0;
  logic [L-1:0][NSTG-1:0] lo0;

  always_comb begin
    for (int l = 0; l < L; l++) begin
      rem0[l] = W'(up_dvd[l] >> NSTG);
      lo0[l]  = up_dvd[l][NSTG-1:0];
    end
  end

  for (genvar k = 0; k < NSTG; k++) begin : g_stg
    logic                   src_v;
    logic [L-1:0][W-1:0]    src_rem;
    logic [L-1:0][W-1:0]    src_dsr;
    logic [L-1:0][NSTG-1:0] src_lo;
    logic [L-1:0][NSTG-1:0] src_q;
    logic [1:0][13:0]       src_heat;
    logic [7:0]             src_day;
    logic                   next_rdy;
    logic [W:0]             trial [L];
    logic [L-1:0]           ge;
    logic [L-1:0][W-1:0]    rem_nxt;
    logic [L-1:0][NSTG-1:0] q_nxt;

    if (k == 0) begin : g_first
      assign src_v    = up_valid;
      assign src_rem  = rem0;
      assign src_dsr  = up_dsr;
      assign src_lo   = lo0;
      assign src_q    = '0;
      assign src_heat = up_heat;
      assign src_day  = up_day;
    end else begin : g_next
      assign src_v    = v_r[k-1];
      assign src_rem  = rem_r[k-1];
      assign src_dsr  = dsr_r[k-1];
      assign src_lo   = lo_r[k-1];
      assign src_q    = q_r[k-1];
      assign src_heat = heat_r[k-1];
      assign src_day  = day_r[k-1];
    end

    if (k == NSTG - 1) begin : g_last
      assign next_rdy = dn_ready;
    end else begin : g_mid
      assign next_rdy = rdy[k+1];
    end

    assign rdy[k] = !v_r[k] || next_rdy;

    // One restoring step per lane: shift in the next dividend bit, subtract if it fits.
    always_comb begin
      for (int l = 0; l < L; l++) begin
        trial[l]   = {src_rem[l], src_lo[l][NSTG-1-k]};
        ge[l]      = trial[l] >= {1'b0, src_dsr[l]};
        rem_nxt[l] = ge[l] ? W'(trial[l] - {1'b0, src_dsr[l]}) : trial[l][W-1:0];
        q_nxt[l]   = {src_q[l][NSTG-2:0], ge[l]};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_r[k] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k] && src_v) begin
        rem_r[k]  <= rem_nxt;
        dsr_r[k]  <= src_dsr;
        lo_r[k]   <= src_lo;
        q_r[k]    <= q_nxt;
        heat_r[k] <= src_heat;
        day_r[k]  <= src_day;
      end
    end
  end

  assign up_ready = rdy[0];
  assign dn_valid = v_r[NSTG-1];
  assign dn_q     = q_r[NSTG-1];
  assign dn_heat  = heat_r[NSTG-1];
  assign dn_day   = day_r[NSTG-1];

endmodule
`default_nettype wire

FILE: rtl/seasonal_live_fuel_moisture_heat.sv
// Seasonal live fuel moisture and heat of combustion. Each transfer on the in_ channel
// carries one season date (calendar month/day or days since May 1) and yields exactly one
// result on the out_ channel, in order. The block accepts one date per clock cycle while
// in_stall is low. Each date passes through five stages of date clamping, polynomial
// evaluation and heat rounding, then the quotient pipeline, which resolves one quotient
// bit per stage for both moisture results at once in NSTG stages, where
// NSTG = max(MOIST_FRAC_BITS + 1, 14), and then one output register. Empty stages close
// up while out_stall is high; in_stall rises only once every stage holds an item and the
// output is stalled.
`timescale 1ns / 1ps
`default_nettype none
module seasonal_live_fuel_moisture_heat #(
  parameter int MOIST_FRAC_BITS = 14
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  slfmh_pkg::in_item_t   in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output slfmh_pkg::out_item_t  out_item
);

  localparam int DVW  = (MOIST_FRAC_BITS + 18 > 34) ? MOIST_FRAC_BITS + 18 : 34;
  localparam int NSTG = (MOIST_FRAC_BITS + 1 > 14) ? MOIST_FRAC_BITS + 1 : 14;
  localparam int QXW  = (NSTG > 16) ? NSTG : 16;
  localparam int L    = slfmh_pkg::NLANE;

  logic                               fr_ready;
  logic                               fr_valid;
  logic [L-1:0][DVW-1:0]              fr_dvd;
  logic [L-1:0][slfmh_pkg::DIV_W-1:0] fr_dsr;
  logic [1:0][13:0]                   fr_heat;
  logic [7:0]                         fr_day;
  logic                               dv_ready;
  logic                               dv_valid;
  logic [L-1:0][NSTG-1:0]             dv_q;
  logic [1:0][13:0]                   dv_heat;
  logic [7:0]                         dv_day;
  logic                               out_rdy;

  slfmh_front #(
    .MOIST_FRAC_BITS(MOIST_FRAC_BITS),
    .DVW(DVW)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (fr_ready),
    .up_item  (in_item),
    .dn_valid (fr_valid),
    .dn_ready (dv_ready),
    .dn_dvd   (fr_dvd),
    .dn_dsr   (fr_dsr),
    .dn_heat  (fr_heat),
    .dn_day   (fr_day)
  );

  slfmh_div #(
    .MOIST_FRAC_BITS(MOIST_FRAC_BITS),
    .DVW(DVW),
    .NSTG(NSTG)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (fr_valid),
    .up_ready (dv_ready),
    .up_dvd   (fr_dvd),
    .up_dsr   (fr_dsr),
    .up_heat  (fr_heat),
    .up_day   (fr_day),
    .dn_valid (dv_valid),
    .dn_ready (out_rdy),
    .dn_q     (dv_q),
    .dn_heat  (dv_heat),
    .dn_day   (dv_day)
  );

  assign in_stall = !fr_ready;

  // Output register: saturate the moisture quotients to the field width.
  logic                  out_valid_r;
  slfmh_pkg::out_item_t  out_item_r, out_item_nxt;
  logic [L-1:0][QXW-1:0] qx;

  assign out_rdy = !out_valid_r || !out_stall;

  always_comb begin
    for (int l = 0; l < L; l++) begin
      qx[l] = QXW'(dv_q[l]);
    end
    out_item_nxt.leaf_moisture = (qx[slfmh_pkg::LANE_LEAF_M] > QXW'(slfmh_pkg::MOIST_MAX)) ?
                                 slfmh_pkg::MOIST_MAX : qx[slfmh_pkg::LANE_LEAF_M][15:0];
    out_item_nxt.wood_moisture = (qx[slfmh_pkg::LANE_WOOD_M] > QXW'(slfmh_pkg::MOIST_MAX)) ?
                                 slfmh_pkg::MOIST_MAX : qx[slfmh_pkg::LANE_WOOD_M][15:0];
    out_item_nxt.leaf_heat     = dv_heat[0];
    out_item_nxt.wood_heat     = dv_heat[1];
    out_item_nxt.season_day    = dv_day;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_rdy) begin
      out_valid_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_rdy && dv_valid) out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // The input backs up only when the whole pipe is full behind a stalled result.
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while output can drain");

  a_day_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.season_day <= slfmh_pkg::SEASON_MAX &&
                   out_item.leaf_heat != 14'd0 && out_item.wood_heat != 14'd0))
    else $error("season day or heat out of range");

  // At the start of the season the heat polynomials reduce to their constant terms.
  a_heat_origin: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.season_day == 8'd0) |->
      (out_item.leaf_heat == 14'd9613 && out_item.wood_heat == 14'd9509))
    else $error("heat at season start mismatches constant term");

endmodule
`default_nettype wire
